### rtl/core/opd_pkg.sv
package opd_pkg;

    // Default number of fraction bits in the fixed-point format.
    localparam int FracBitsDefault = 16;

    // Operand slots.
    localparam int NumSlots = 9;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_GAIN_RATE     = 2'd0,
        REG_GAIN_VELOCITY = 2'd1,
        REG_GAIN_ATTITUDE = 2'd2
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMAT,
        ST_EVEC,
        ST_DMAT,
        ST_FINAL,
        ST_FLUSH,
        ST_OUT
    } state_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -64'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

### rtl/core/opd_mac.sv
// Shared multiplier: registers the fixed-point product of two 32-bit operands.
module opd_mac #(
    parameter int FRAC_BITS = opd_pkg::FracBitsDefault
) (
    input  logic               clk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod
);
    import opd_pkg::*;

    logic signed [63:0] full;
    logic signed [63:0] prod_reg;

    // Exact product, then arithmetic shift by the fraction width.
    assign full = 64'(op_a) * 64'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= full >>> FRAC_BITS;
    end

    assign prod = prod_reg;
endmodule

### rtl/core/orientation_pd_control_unit.sv
// Attitude PD controller on rotation matrices, fixed point.
// Input channel (in_valid/in_ready): each beat loads one slot of three words
// selected by mode (0-2 measured rows, 3-5 desired rows, 6 w, 7 wd, 8 ff).
// A beat without last is stored and yields no result, so such beats can
// be taken back to back.
// A beat with last starts a computation on a single shared multiplier:
// 27 products for E, state ST_EVEC for the error vector, 36 products for
// the rate term, 9 for the gains and ST_FLUSH to drain the multiplier register.
// out_valid rises when the sequencer enters ST_OUT, after ST_FLUSH.
// The block takes no new beat until the result beat has gone.
// Output channel (out_valid/out_ready): the torque stays in its register
// while the receiver stalls, and the input stays blocked meanwhile.
// Configuration channel (cfg_valid/cfg_ready): always ready; index 0..2
// writes a gain, other indexes are ignored.
// Reset clears the operand store, the gains and all control state.
module orientation_pd_control_unit #(
    parameter int FRAC_BITS = opd_pkg::FracBitsDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         mode,
    input  logic signed [31:0] comp_x,
    input  logic signed [31:0] comp_y,
    input  logic signed [31:0] comp_z,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] torque_x,
    output logic signed [31:0] torque_y,
    output logic signed [31:0] torque_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import opd_pkg::*;

    state_t state_reg, state_next;
    logic signed [31:0] store_reg [27];
    logic signed [31:0] g_reg [3];
    logic signed [31:0] em_reg [9];
    logic signed [31:0] ev_reg [3];
    logic signed [31:0] dv_reg [3];
    logic signed [31:0] tq_reg [3];
    logic signed [63:0] acc_reg;

    // Loop counters of the sequencer.
    logic [1:0] i_reg, i_next;
    logic [1:0] j_reg, j_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] j_top;

    // Tags that travel with a product through the multiplier register.
    logic       pv_reg;
    logic       pfirst_reg;
    logic       plast_reg;
    logic       psub_reg;
    state_t     pkind_reg;
    logic [3:0] pidx_reg;

    logic signed [31:0] op_a, op_b;
    logic signed [63:0] prod;
    logic       issue, first, fin, sub;
    logic [3:0] tidx;
    logic [1:0] pa, pb, row, col;
    logic signed [63:0] base, sum;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == ST_OUT);
    assign torque_x  = tq_reg[0];
    assign torque_y  = tq_reg[1];
    assign torque_z  = tq_reg[2];

    opd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk (clk),
        .op_a(op_a),
        .op_b(op_b),
        .prod(prod)
    );

    // Skew-matrix entry of a vector, saturated.
    function automatic logic signed [31:0] skw(input logic signed [31:0] vx,
        input logic signed [31:0] vy, input logic signed [31:0] vz,
        input logic [1:0] i, input logic [1:0] j);
        logic signed [31:0] r;
        begin
            r = '0;
            if (i == 2'd0 && j == 2'd1) r = sat32(-64'(vz));
            if (i == 2'd0 && j == 2'd2) r = vy;
            if (i == 2'd1 && j == 2'd0) r = vz;
            if (i == 2'd1 && j == 2'd2) r = sat32(-64'(vx));
            if (i == 2'd2 && j == 2'd0) r = sat32(-64'(vy));
            if (i == 2'd2 && j == 2'd1) r = vx;
            return r;
        end
    endfunction

    // Operand selection per step, with the tags of the product.
    always_comb
    begin
        op_a  = '0;
        op_b  = '0;
        issue = 1'b0;
        first = 1'b0;
        fin   = 1'b0;
        sub   = 1'b0;
        tidx  = '0;
        pa    = '0;
        pb    = '0;
        row   = '0;
        col   = '0;
        case (state_reg)
            ST_EMAT:
            begin
                // E[i][j] = sum over k of R[i][k] * Rd[j][k].
                issue = 1'b1;
                op_a  = store_reg[5'(i_reg * 3 + k_reg)];
                op_b  = store_reg[5'(9 + j_reg * 3 + k_reg)];
                first = (k_reg == 2'd0);
                fin   = (k_reg == 2'd2);
                tidx  = 4'(i_reg * 3 + j_reg);
            end
            ST_DMAT:
            begin
                // Component i of de is D[a][b] - D[b][a]; steps 0 and 1 build
                // D[a][b], steps 2 and 3 take off D[b][a].
                issue = 1'b1;
                case (i_reg)
                    2'd0:
                    begin
                        pa = 2'd2;
                        pb = 2'd1;
                    end
                    2'd1:
                    begin
                        pa = 2'd0;
                        pb = 2'd2;
                    end
                    default:
                    begin
                        pa = 2'd1;
                        pb = 2'd0;
                    end
                endcase
                row = j_reg[1] ? pb : pa;
                col = j_reg[1] ? pa : pb;
                // Even step: sw[row][k]*E[k][col]; odd: -E[row][k]*swd[k][col].
                if (!j_reg[0])
                begin
                    op_a = skw(store_reg[18], store_reg[19], store_reg[20], row, k_reg);
                    op_b = em_reg[4'(k_reg * 3 + col)];
                    sub  = j_reg[1];
                end
                else
                begin
                    op_a = em_reg[4'(row * 3 + k_reg)];
                    op_b = skw(store_reg[21], store_reg[22], store_reg[23], k_reg, col);
                    sub  = !j_reg[1];
                end
                first = (j_reg == 2'd0) && (k_reg == 2'd0);
                fin   = (j_reg == 2'd3) && (k_reg == 2'd2);
                tidx  = 4'(i_reg);
            end
            ST_FINAL:
            begin
                // Gain k on term k of component i, taken off the feedforward.
                issue = 1'b1;
                sub   = 1'b1;
                op_a  = g_reg[k_reg];
                case (k_reg)
                    2'd0:    op_b = dv_reg[i_reg];
                    2'd1:    op_b = sat32(64'(store_reg[5'(18 + i_reg)])
                                          - 64'(store_reg[5'(21 + i_reg)]));
                    default: op_b = ev_reg[i_reg];
                endcase
                first = (k_reg == 2'd0);
                fin   = (k_reg == 2'd2);
                tidx  = 4'(i_reg);
            end
            default: ;
        endcase
    end

    // Sequencer: nested counters k, j, i walk each phase.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        j_top      = (state_reg == ST_DMAT) ? 2'd3 : 2'd2;
        case (state_reg)
            ST_IDLE:
                if (in_valid && last)
                begin
                    state_next = ST_EMAT;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            ST_EMAT, ST_DMAT, ST_FINAL:
            begin
                if (k_reg != 2'd2)
                    k_next = k_reg + 2'd1;
                else
                begin
                    k_next = '0;
                    if (state_reg != ST_FINAL && j_reg != j_top)
                        j_next = j_reg + 2'd1;
                    else
                    begin
                        j_next = '0;
                        if (i_reg != 2'd2)
                            i_next = i_reg + 2'd1;
                        else
                        begin
                            i_next = '0;
                            case (state_reg)
                                ST_EMAT: state_next = ST_EVEC;
                                ST_DMAT: state_next = ST_FINAL;
                                default: state_next = ST_FLUSH;
                            endcase
                        end
                    end
                end
            end
            ST_EVEC:  state_next = ST_DMAT;
            ST_FLUSH: state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, operand store and gains.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            pv_reg     <= 1'b0;
            pfirst_reg <= 1'b0;
            plast_reg  <= 1'b0;
            psub_reg   <= 1'b0;
            pkind_reg  <= ST_IDLE;
            pidx_reg   <= '0;
            for (int n = 0; n < 27; n++) store_reg[n] <= '0;
            for (int n = 0; n < 3; n++) g_reg[n] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            pv_reg     <= issue;
            pfirst_reg <= first;
            plast_reg  <= fin;
            psub_reg   <= sub;
            pkind_reg  <= state_reg;
            pidx_reg   <= tidx;
            if (in_valid && in_ready && mode < 4'(NumSlots))
            begin
                store_reg[5'(mode * 3)]     <= comp_x;
                store_reg[5'(mode * 3 + 1)] <= comp_y;
                store_reg[5'(mode * 3 + 2)] <= comp_z;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_RATE:     g_reg[0] <= cfg_data;
                    REG_GAIN_VELOCITY: g_reg[1] <= cfg_data;
                    REG_GAIN_ATTITUDE: g_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Accumulation on the multiplier register's output and its tags; torque sums start at ff.
    always_comb
    begin
        if (!pfirst_reg)
            base = acc_reg;
        else if (pkind_reg == ST_FINAL)
            base = 64'(store_reg[5'(24 + pidx_reg)]);
        else
            base = '0;
        sum = psub_reg ? base - prod : base + prod;
    end

    // Results of each phase. The error vector is formed in the cycle after
    // the E products; it needs no entry of the last E row past column 1.
    always_ff @(posedge clk)
    begin
        if (pv_reg)
        begin
            acc_reg <= sum;
            if (plast_reg)
            begin
                case (pkind_reg)
                    ST_EMAT: em_reg[pidx_reg] <= sat32(sum);
                    ST_DMAT: dv_reg[pidx_reg[1:0]] <= sat32(sum >>> 1);
                    default: tq_reg[pidx_reg[1:0]] <= sat32(sum);
                endcase
            end
        end
        if (state_reg == ST_EVEC)
        begin
            ev_reg[0] <= sat32(((64'(em_reg[7]) - 64'(em_reg[5])) >>> 1));
            ev_reg[1] <= sat32(((64'(em_reg[2]) - 64'(em_reg[6])) >>> 1));
            ev_reg[2] <= sat32(((64'(em_reg[3]) - 64'(em_reg[1])) >>> 1));
        end
    end
endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import opd_pkg::*;

    localparam int FRAC = 16;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [3:0] mode = '0;
    logic signed [31:0] comp_x = '0;
    logic signed [31:0] comp_y = '0;
    logic signed [31:0] comp_z = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } torque_t;

    // Predictor state: operand store and gains.
    longint operands [27];
    longint gain_rate, gain_vel, gain_att;
    torque_t torque_queue[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    int errors = 0;
    longint cycles = 0;

    orientation_pd_control_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .torque_x(torque_x), .torque_y(torque_y), .torque_z(torque_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Fixed-point product with floor shift.
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic torque_t pd_torque();
        longint em [3][3];
        longint sw [3][3];
        longint swd [3][3];
        longint d [3][3];
        longint ev [3];
        longint dev [3];
        longint res [3];
        longint acc, dw;
        torque_t t;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += qmul(operands[i*3+k], operands[9+j*3+k]);
                em[i][j] = clamp32(acc);
            end
        ev[0] = clamp32((em[2][1] - em[1][2]) >>> 1);
        ev[1] = clamp32((em[0][2] - em[2][0]) >>> 1);
        ev[2] = clamp32((em[1][0] - em[0][1]) >>> 1);
        // Skew matrices of w and wd, kept in 32-bit range.
        for (int s = 0; s < 2; s++)
        begin
            longint vx, vy, vz;
            longint m [3][3];
            vx = operands[18+s*3]; vy = operands[19+s*3]; vz = operands[20+s*3];
            m[0][0] = 0;   m[0][1] = -vz; m[0][2] = vy;
            m[1][0] = vz;  m[1][1] = 0;   m[1][2] = -vx;
            m[2][0] = -vy; m[2][1] = vx;  m[2][2] = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    if (s == 0) sw[i][j] = clamp32(m[i][j]);
                    else swd[i][j] = clamp32(m[i][j]);
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                begin
                    acc += qmul(sw[i][k], em[k][j]);
                    acc -= qmul(em[i][k], swd[k][j]);
                end
                d[i][j] = acc;
            end
        dev[0] = clamp32((d[2][1] - d[1][2]) >>> 1);
        dev[1] = clamp32((d[0][2] - d[2][0]) >>> 1);
        dev[2] = clamp32((d[1][0] - d[0][1]) >>> 1);
        for (int i = 0; i < 3; i++)
        begin
            dw = clamp32(operands[18+i] - operands[21+i]);
            res[i] = clamp32(operands[24+i] - qmul(gain_rate, dev[i])
                     - qmul(gain_vel, dw) - qmul(gain_att, ev[i]));
        end
        t.x = res[0][31:0]; t.y = res[1][31:0]; t.z = res[2][31:0];
        return t;
    endfunction

    // Send one beat and update the prediction when it is accepted.
    // Valid stays high after the beat; an idle gap or drain() drops it.
    task automatic send_beat(logic [3:0] m, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] z, logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m; comp_x <= x; comp_y <= y; comp_z <= z; last <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (m < NumSlots)
        begin
            operands[m*3] = x; operands[m*3+1] = y; operands[m*3+2] = z;
        end
        if (l)
            torque_queue.push_back(pd_torque());
        @(negedge clk);
    endtask

    task automatic write_gain(logic [1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_GAIN_RATE: gain_rate = $signed(value);
            REG_GAIN_VELOCITY: gain_vel = $signed(value);
            REG_GAIN_ATTITUDE: gain_att = $signed(value);
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (torque_queue.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic set_gains(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        drain();
        write_gain(REG_GAIN_RATE, a);
        write_gain(REG_GAIN_VELOCITY, b);
        write_gain(REG_GAIN_ATTITUDE, c);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(131072) - 65536;
            3: return {{14{1'b0}}, 18'($urandom())} ^ {32{1'($urandom_range(1))}};
            default: return $urandom();
        endcase
    endfunction

    // Receiver: stalls at random, checks every result beat.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (torque_queue.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                torque_t t;
                t = torque_queue.pop_front();
                if (torque_x !== t.x)
                begin
                    $error("torque_x expected %0d actual %0d", t.x, torque_x);
                    errors++;
                end
                if (torque_y !== t.y)
                begin
                    $error("torque_y expected %0d actual %0d", t.y, torque_y);
                    errors++;
                end
                if (torque_z !== t.z)
                begin
                    $error("torque_z expected %0d actual %0d", t.z, torque_z);
                    errors++;
                end
            end
        end
    end

    // Directed: field extremes, every slot, unused modes and loads with no result.
    task automatic test_directed();
        send_beat(4'd0, 0, 0, 0, 1'b1);
        send_beat(4'd0, 32'sh10000, 0, 0, 1'b0);
        send_beat(4'd1, 0, 32'sh10000, 0, 1'b0);
        send_beat(4'd2, 0, 0, 32'sh10000, 1'b0);
        send_beat(4'd3, 0, 32'sh10000, 0, 1'b0);
        send_beat(4'd4, -32'sh10000, 0, 0, 1'b0);
        send_beat(4'd5, 0, 0, 32'sh10000, 1'b0);
        send_beat(4'd6, 32'sh8000, -32'sh4000, 32'sh20000, 1'b0);
        send_beat(4'd7, -32'sh8000, 32'sh1000, 0, 1'b0);
        send_beat(4'd8, 32'sh100, -32'sh100, 32'sh7fff, 1'b1);
        send_beat(4'd6, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
        send_beat(4'd7, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);
        send_beat(4'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
        send_beat(4'd3, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
        send_beat(4'd9, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
        send_beat(4'd15, 32'h12345678, 0, 0, 1'b0);
        send_beat(4'd12, 0, 0, 0, 1'b1);
        send_beat(4'd8, 32'h80000000, 32'h7fffffff, 0, 1'b1);
    endtask

    // Random: mostly full loads of nine slots closed by last, plus noise.
    task automatic test_random(int n);
        int sent;
        int slot;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) < 8)
            begin
                for (slot = 0; slot < NumSlots; slot++)
                    send_beat(slot[3:0], rand_comp(), rand_comp(), rand_comp(),
                              slot == NumSlots - 1);
                sent += NumSlots;
            end
            else
            begin
                send_beat(4'($urandom()), rand_comp(), rand_comp(), rand_comp(),
                          1'($urandom()));
                sent++;
            end
        end
    endtask

    // Long receiver hold-off while beats keep coming.
    task automatic test_backpressure();
        hold_off = 400;
        test_random(40);
    endtask

    initial
    begin
        for (int i = 0; i < 27; i++)
            operands[i] = 0;
        gain_rate = 0; gain_vel = 0; gain_att = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        set_gains(32'h00010000, 32'h00008000, 32'h00020000);
        test_directed();
        set_gains(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        test_directed();
        test_random(150);
        send_idle_pct = 54;
        set_gains($urandom(), $urandom(), $urandom());
        test_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 54;
        set_gains(32'h80000000, 32'h7fffffff, 32'h80000000);
        test_random(300);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        set_gains(32'hffff0000, 32'h00000001, 32'h0000ffff);
        test_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        set_gains($urandom(), $urandom(), $urandom());
        test_random(350);
        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

### filelist.f
rtl/core/opd_pkg.sv
rtl/core/opd_mac.sv
rtl/core/orientation_pd_control_unit.sv
dv/tb.sv
